// File: rtl/paa_pkg.sv
package paa_pkg;

  // configuration register file
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 13;
  localparam int LEN_REG_W   = 13;
  localparam int CNT_REG_W   = 7;

  localparam logic [LEN_REG_W-1:0] RESET_SERIES_LENGTH = 13'd256;
  localparam logic [CNT_REG_W-1:0] RESET_SEGMENT_COUNT = 7'd16;

  // result word
  localparam int OUT_INDEX_W = 6;

  // words of slack between accumulator and mean unit
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SERIES_LENGTH = 1'b0,
    REG_SEGMENT_COUNT = 1'b1
  } cfg_reg_t;

endpackage

// File: rtl/paa_divu.sv
module paa_divu #(
  parameter int NW = 28,
  parameter int DW = 13
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          busy,
  output logic          done,
  output logic [NW-1:0] quotient,
  output logic [DW-1:0] remainder
);

  localparam int CNT_W = $clog2(NW + 1);

  logic [NW-1:0]    quo;
  logic [DW-1:0]    rem;
  logic [DW-1:0]    dsr;
  logic [CNT_W-1:0] cnt;
  logic [DW:0]      shifted;
  logic [DW:0]      diff;

  // one quotient bit per cycle, restoring
  assign shifted = {rem, quo[NW-1]};
  assign diff    = shifted - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
      cnt <= CNT_W'(NW);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      if (!diff[DW]) begin
        rem <= diff[DW-1:0];
        quo <= {quo[NW-2:0], 1'b1};
      end else begin
        rem <= shifted[DW-1:0];
        quo <= {quo[NW-2:0], 1'b0};
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

// File: rtl/paa_front.sv
module paa_front
  import paa_pkg::*;
#(
  parameter int SAMPLE_WIDTH      = 16,
  parameter int MAX_SERIES_LENGTH = 4096,
  parameter int MAX_SEGMENTS      = 64,
  parameter int LEN_W             = 13,
  parameter int CNT_W             = 7,
  parameter int IDX_W             = 6,
  parameter int SUM_W             = 28,
  parameter int ENTRY_W           = 48
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic [CFG_INDEX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic                    push,
  output logic                    full,
  input  logic [SAMPLE_WIDTH-1:0] sample,
  output logic                    q_push,
  output logic [ENTRY_W-1:0]      q_data,
  input  logic                    q_full
);

  logic [LEN_REG_W-1:0] len_reg;
  logic [CNT_REG_W-1:0] cnt_reg;
  logic                 derive_start;

  logic [LEN_W-1:0]     eff_len;
  logic [CNT_W-1:0]     eff_cnt;
  logic [31:0]          cnt_wide;

  logic                 cdiv_busy;
  logic                 cdiv_done;
  logic [LEN_W-1:0]     cdiv_quo;
  logic [CNT_W-1:0]     cdiv_rem;

  logic [LEN_W-1:0]     base_len;
  logic [CNT_W-1:0]     long_cnt;
  logic [CNT_W-1:0]     seg_total;

  logic signed [SUM_W-1:0] run_sum;
  logic signed [SUM_W-1:0] run_sum_next;
  logic [LEN_W-1:0]     count;
  logic [LEN_W-1:0]     count_next;
  logic [IDX_W-1:0]     cur_seg;
  logic [LEN_W-1:0]     seg_len;
  logic                 accept;
  logic                 close;
  logic                 last;

  // clamp the registers to the lengths actually used
  always_comb begin
    if (len_reg == '0) begin
      eff_len = LEN_W'(1);
    end else if (32'(len_reg) > 32'(MAX_SERIES_LENGTH)) begin
      eff_len = LEN_W'(MAX_SERIES_LENGTH);
    end else begin
      eff_len = LEN_W'(len_reg);
    end
    cnt_wide = 32'(cnt_reg);
    if (cnt_wide == 32'd0) begin
      cnt_wide = 32'd1;
    end
    if (cnt_wide > 32'(MAX_SEGMENTS)) begin
      cnt_wide = 32'(MAX_SEGMENTS);
    end
    if (cnt_wide > 32'(eff_len)) begin
      cnt_wide = 32'(eff_len);
    end
    eff_cnt = CNT_W'(cnt_wide);
  end

  paa_divu #(
    .NW(LEN_W),
    .DW(CNT_W)
  ) u_cfg_div (
    .clk       (clk),
    .rst       (rst),
    .start     (derive_start),
    .dividend  (eff_len),
    .divisor   (eff_cnt),
    .busy      (cdiv_busy),
    .done      (cdiv_done),
    .quotient  (cdiv_quo),
    .remainder (cdiv_rem)
  );

  assign full   = derive_start || cdiv_busy || cdiv_done || q_full;
  assign accept = push && !full;

  assign seg_len      = base_len + LEN_W'(CNT_W'(cur_seg) < long_cnt);
  assign run_sum_next = run_sum +
                        {{(SUM_W-SAMPLE_WIDTH){sample[SAMPLE_WIDTH-1]}}, sample};
  assign count_next   = count + LEN_W'(1);
  assign close        = (count_next == seg_len);
  assign last         = ((CNT_W'(cur_seg) + CNT_W'(1)) == seg_total);

  assign q_push = accept && close;
  assign q_data = {run_sum_next, seg_len, cur_seg, last};

  always_ff @(posedge clk) begin
    if (rst) begin
      len_reg      <= RESET_SERIES_LENGTH;
      cnt_reg      <= RESET_SEGMENT_COUNT;
      derive_start <= 1'b1;
      run_sum      <= '0;
      count        <= '0;
      cur_seg      <= '0;
    end else begin
      derive_start <= cfg_write;
      if (cfg_write) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_SERIES_LENGTH: len_reg <= cfg_data[LEN_REG_W-1:0];
          REG_SEGMENT_COUNT: cnt_reg <= cfg_data[CNT_REG_W-1:0];
          default: ;
        endcase
        run_sum <= '0;
        count   <= '0;
        cur_seg <= '0;
      end else if (accept) begin
        if (close) begin
          run_sum <= '0;
          count   <= '0;
          cur_seg <= last ? '0 : cur_seg + IDX_W'(1);
        end else begin
          run_sum <= run_sum_next;
          count   <= count_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cdiv_done) begin
      base_len  <= cdiv_quo;
      long_cnt  <= cdiv_rem;
      seg_total <= eff_cnt;
    end
  end

endmodule

// File: rtl/paa_queue.sv
module paa_queue #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]  slots [DEPTH];
  logic [PTR_W-1:0]  head;
  logic [PTR_W-1:0]  tail;
  logic [FILL_W-1:0] fill;
  logic              do_push;
  logic              do_pop;

  assign full     = (fill == FILL_W'(DEPTH));
  assign empty    = (fill == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slots[head];

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      fill <= '0;
    end else begin
      if (do_push) begin
        tail <= (tail == PTR_W'(DEPTH - 1)) ? '0 : tail + PTR_W'(1);
      end
      if (do_pop) begin
        head <= (head == PTR_W'(DEPTH - 1)) ? '0 : head + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + FILL_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - FILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[tail] <= push_data;
    end
  end

endmodule

// File: rtl/paa_back.sv
module paa_back
  import paa_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 16,
  parameter int LEN_W        = 13,
  parameter int IDX_W        = 6,
  parameter int SUM_W        = 28,
  parameter int ENTRY_W      = 48
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [ENTRY_W-1:0]      q_data,
  input  logic                    q_empty,
  output logic                    q_pop,
  output logic                    empty,
  input  logic                    pop,
  output logic [SAMPLE_WIDTH-1:0] segment_mean,
  output logic [OUT_INDEX_W-1:0]  segment_index,
  output logic                    series_end
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_WAIT
  } state_t;

  state_t            state;
  logic              out_valid;
  logic              neg;
  logic [IDX_W-1:0]  idx;
  logic              last;

  logic [SUM_W-1:0]  e_sum;
  logic [LEN_W-1:0]  e_len;
  logic [IDX_W-1:0]  e_idx;
  logic              e_last;
  logic [SUM_W-1:0]  mag;

  logic              div_done;
  logic [SUM_W-1:0]  div_quo;
  logic [SUM_W-1:0]  mean_full;
  logic              load;

  assign {e_sum, e_len, e_idx, e_last} = q_data;

  // divide magnitudes so the quotient truncates toward zero
  assign mag   = e_sum[SUM_W-1] ? (~e_sum + SUM_W'(1)) : e_sum;
  assign q_pop = (state == S_IDLE) && !q_empty;

  paa_divu #(
    .NW(SUM_W),
    .DW(LEN_W)
  ) u_mean_div (
    .clk       (clk),
    .rst       (rst),
    .start     (q_pop),
    .dividend  (mag),
    .divisor   (e_len),
    .busy      (),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder ()
  );

  assign mean_full = neg ? (~div_quo + SUM_W'(1)) : div_quo;
  assign load      = (state == S_WAIT) && (!out_valid || pop);
  assign empty     = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_pop) begin
            neg   <= e_sum[SUM_W-1];
            idx   <= e_idx;
            last  <= e_last;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (load) begin
            segment_mean  <= mean_full[SAMPLE_WIDTH-1:0];
            segment_index <= OUT_INDEX_W'(32'(idx));
            series_end    <= last;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/piecewise_aggregate_approximation_unit.sv
// piecewise aggregate approximation of a stream of signed q8.8 samples. back-to-back
// series of the configured length are cut into the configured number of segments (count
// clamped to 1..MAX_SEGMENTS and to the series length, length clamped to
// 1..MAX_SERIES_LENGTH); the first (length mod count) segments are one sample longer.
// each closed segment yields one word: its mean truncated toward zero, its index in
// the series and a flag on the last segment. the accumulator takes one sample per
// cycle while full is low; each segment mean goes through a shift-subtract divider in
// the back end (SUM_W = SAMPLE_WIDTH + log2 of MAX_SERIES_LENGTH), which takes one
// segment at a time and accepts the next only once the last mean is registered; a
// two-word queue absorbs short bursts. after reset and after each configuration
// write full stays high while the segment lengths are derived by a second divider,
// and the running segment restarts at the first sample of a series.
module piecewise_aggregate_approximation_unit
  import paa_pkg::*;
#(
  parameter int SAMPLE_WIDTH      = 16,
  parameter int MAX_SERIES_LENGTH = 4096,
  parameter int MAX_SEGMENTS      = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  // configuration registers
  input  logic                    cfg_write,
  input  logic [CFG_INDEX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  // sample words in
  input  logic                    push,
  output logic                    full,
  input  logic [SAMPLE_WIDTH-1:0] sample,
  // segment words out
  output logic                    empty,
  input  logic                    pop,
  output logic [SAMPLE_WIDTH-1:0] segment_mean,
  output logic [OUT_INDEX_W-1:0]  segment_index,
  output logic                    series_end
);

  // sample counts and segment lengths
  localparam int LEN_W   = $clog2(MAX_SERIES_LENGTH + 1);
  // effective segment count
  localparam int CNT_W   = $clog2(MAX_SEGMENTS + 1);
  // segment position within a series
  localparam int IDX_W   = $clog2(MAX_SEGMENTS);
  // segment sum, never overflows for the longest segment
  localparam int SUM_W   = SAMPLE_WIDTH + $clog2(MAX_SERIES_LENGTH);
  // queued word: sum, length, index, last flag
  localparam int ENTRY_W = SUM_W + LEN_W + IDX_W + 1;

  logic               q_push;
  logic [ENTRY_W-1:0] q_wdata;
  logic               q_full;
  logic               q_pop;
  logic [ENTRY_W-1:0] q_rdata;
  logic               q_empty;

  // accumulator and segment boundary logic
  paa_front #(
    .SAMPLE_WIDTH      (SAMPLE_WIDTH),
    .MAX_SERIES_LENGTH (MAX_SERIES_LENGTH),
    .MAX_SEGMENTS      (MAX_SEGMENTS),
    .LEN_W             (LEN_W),
    .CNT_W             (CNT_W),
    .IDX_W             (IDX_W),
    .SUM_W             (SUM_W),
    .ENTRY_W           (ENTRY_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .full      (full),
    .sample    (sample),
    .q_push    (q_push),
    .q_data    (q_wdata),
    .q_full    (q_full)
  );

  // closed segments waiting for the divider
  paa_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  // mean divider and output register
  paa_back #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .LEN_W        (LEN_W),
    .IDX_W        (IDX_W),
    .SUM_W        (SUM_W),
    .ENTRY_W      (ENTRY_W)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_data        (q_rdata),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .empty         (empty),
    .pop           (pop),
    .segment_mean  (segment_mean),
    .segment_index (segment_index),
    .series_end    (series_end)
  );

endmodule

// File: rtl/paa_checker.sv
module paa_checker
  import paa_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 16
) (
  input logic                    clk,
  input logic                    rst,
  input logic                    cfg_write,
  input logic                    full,
  input logic                    empty,
  input logic                    pop,
  input logic [SAMPLE_WIDTH-1:0] segment_mean,
  input logic [OUT_INDEX_W-1:0]  segment_index,
  input logic                    series_end
);

  // length derivation blocks input right after reset
  a_reset_full: assert property (@(posedge clk) rst |=> full)
    else $error("full not raised after reset");

  // no word left over after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result word present after reset");

  // a register write restarts length derivation
  a_cfg_full: assert property (@(posedge clk) disable iff (rst)
    cfg_write |=> full)
    else $error("input open while segment lengths are derived");

  // a waiting word is held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(segment_mean) &&
                          $stable(segment_index) && $stable(series_end)))
    else $error("result word changed before pop");

endmodule

bind piecewise_aggregate_approximation_unit paa_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_paa_checker (.*);

// File: sim/tb_top.sv
module tb_top;
  import paa_pkg::*;

  localparam int SAMPLE_W       = 16;
  localparam int MAX_LEN        = 4096;
  localparam int MAX_SEG        = 64;
  // idle wait before a write covers the mean divider and two words of queue slack
  localparam int SETTLE_CYCLES  = 64;
  localparam int DRAIN_CYCLES   = 100;
  localparam int RANDOM_SAMPLES = 1150;

  typedef enum logic {ENTRY_SAMPLE, ENTRY_WRITE} entry_kind_t;

  // one entry of the stimulus stream: a sample word or a register write
  typedef struct {
    entry_kind_t           kind;
    logic [SAMPLE_W-1:0]   value;
    cfg_reg_t              target;
    logic [CFG_DATA_W-1:0] data;
  } stim_entry_t;

  typedef struct {
    logic [SAMPLE_W-1:0]    mean;
    logic [OUT_INDEX_W-1:0] index;
    logic                   last;
  } segment_word_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   push = 1'b0;
  logic                   full;
  logic [SAMPLE_W-1:0]    sample = '0;
  logic                   empty;
  logic                   pop = 1'b0;
  logic [SAMPLE_W-1:0]    segment_mean;
  logic [OUT_INDEX_W-1:0] segment_index;
  logic                   series_end;

  stim_entry_t   sample_stream[$];
  segment_word_t expected_means[$];
  int            error_count = 0;

  // sender and receiver pacing
  int idle_cycles = 0;
  int send_gap = 0;
  bit send_burst = 1'b0;
  int take_gap = 0;
  bit take_burst = 1'b0;

  // predictor state at the block's widths
  logic [LEN_REG_W-1:0]   len_reg;
  logic [CNT_REG_W-1:0]   count_reg;
  logic signed [27:0]     seg_sum;
  logic [12:0]            seg_fill;
  logic [5:0]             seg_pos;
  logic [12:0]            base_len;
  logic [5:0]             long_segs;
  logic [6:0]             seg_total;

  piecewise_aggregate_approximation_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .push          (push),
    .full          (full),
    .sample        (sample),
    .empty         (empty),
    .pop           (pop),
    .segment_mean  (segment_mean),
    .segment_index (segment_index),
    .series_end    (series_end)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task flag_error(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    error_count++;
  endtask

  // clamp length and count, split the series, start over at its first sample
  task restart_series();
    int len;
    int cnt;
    len = len_reg;
    cnt = count_reg;
    if (len < 1) len = 1;
    if (len > MAX_LEN) len = MAX_LEN;
    if (cnt < 1) cnt = 1;
    if (cnt > MAX_SEG) cnt = MAX_SEG;
    if (cnt > len) cnt = len;
    seg_total = 7'(cnt);
    base_len  = 13'(len / cnt);
    long_segs = 6'(len % cnt);
    seg_sum   = '0;
    seg_fill  = '0;
    seg_pos   = '0;
  endtask

  task write_register(input cfg_reg_t target, input logic [CFG_DATA_W-1:0] data);
    case (target)
      REG_SERIES_LENGTH: len_reg = data[LEN_REG_W-1:0];
      REG_SEGMENT_COUNT: count_reg = data[CNT_REG_W-1:0];
    endcase
    restart_series();
  endtask

  // add one sample; a closed segment queues its expected word
  task accumulate(input logic [SAMPLE_W-1:0] s);
    int            seg_len;
    int            quotient;
    segment_word_t w;
    seg_sum  = seg_sum + $signed(s);
    seg_fill = seg_fill + 13'd1;
    // the leading (length mod count) segments are one sample longer
    seg_len  = base_len + ((seg_pos < long_segs) ? 1 : 0);
    if (seg_fill >= seg_len) begin
      // signed int division truncates toward zero
      quotient = int'(seg_sum) / seg_len;
      w.mean   = quotient[SAMPLE_W-1:0];
      w.index  = seg_pos;
      w.last   = (seg_pos + 1 == seg_total);
      expected_means.push_back(w);
      seg_sum  = '0;
      seg_fill = '0;
      seg_pos  = (seg_pos + 1 >= seg_total) ? '0 : seg_pos + 6'd1;
    end
  endtask

  task add_sample(input logic [SAMPLE_W-1:0] v);
    stim_entry_t e;
    e.kind   = ENTRY_SAMPLE;
    e.value  = v;
    e.target = REG_SERIES_LENGTH;
    e.data   = '0;
    sample_stream.push_back(e);
  endtask

  task add_write(input cfg_reg_t target, input logic [CFG_DATA_W-1:0] data);
    stim_entry_t e;
    e.kind   = ENTRY_WRITE;
    e.value  = '0;
    e.target = target;
    e.data   = data;
    sample_stream.push_back(e);
  endtask

  // mostly uniform, with the extremes and small negatives mixed in
  function automatic logic [SAMPLE_W-1:0] random_sample();
    logic [SAMPLE_W-1:0] v;
    v = SAMPLE_W'($urandom);
    case ($urandom_range(0, 9))
      0: v = 16'h7FFF;
      1: v = 16'h8000;
      2: v = 16'hFFFF;
      3: v = 16'h0000;
      default: ;
    endcase
    return v;
  endfunction

  // driver: sample words and register writes, writes only once the block is quiet
  always @(posedge clk) begin : driver
    stim_entry_t head;
    logic        hold;
    logic        next_push;
    logic        next_write;
    if (rst) begin
      push      <= 1'b0;
      cfg_write <= 1'b0;
      send_gap  = 0;
      idle_cycles = 0;
      len_reg   = RESET_SERIES_LENGTH;
      count_reg = RESET_SEGMENT_COUNT;
      restart_series();
    end else begin
      if (push && !full) accumulate(sample);
      if (cfg_write) write_register(cfg_reg_t'(cfg_index), cfg_data);
      // cycles with nothing in flight toward the result side
      if (expected_means.size() == 0 && !push && !cfg_write) idle_cycles++;
      else idle_cycles = 0;
      hold       = push && full;
      next_push  = hold;
      next_write = 1'b0;
      if (!hold) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (sample_stream.size() > 0) begin
          head = sample_stream[0];
          if (head.kind == ENTRY_SAMPLE) begin
            next_push = 1'b1;
            sample <= head.value;
            void'(sample_stream.pop_front());
            // runs of back-to-back words between stretches of random gaps
            if ($urandom_range(0, 31) == 0) send_burst = !send_burst;
            send_gap = send_burst ? 0 : $urandom_range(0, 7);
          end else if (idle_cycles >= SETTLE_CYCLES) begin
            next_write = 1'b1;
            cfg_index <= head.target;
            cfg_data  <= head.data;
            void'(sample_stream.pop_front());
          end
        end
      end
      push      <= next_push;
      cfg_write <= next_write;
    end
  end

  // monitor: pops segment words with random stalls and checks every field
  always @(posedge clk) begin : monitor
    segment_word_t want;
    if (rst) begin
      pop <= 1'b0;
      take_gap = 0;
    end else begin
      if (pop && !empty) begin
        if (expected_means.size() == 0) begin
          flag_error($sformatf("unexpected word: mean %0d index %0d end %0b",
                               $signed(segment_mean), segment_index, series_end));
        end else begin
          want = expected_means.pop_front();
          if (segment_mean !== want.mean)
            flag_error($sformatf("segment %0d mean: expected %0d got %0d", want.index,
                                 $signed(want.mean), $signed(segment_mean)));
          if (segment_index !== want.index)
            flag_error($sformatf("segment index: expected %0d got %0d",
                                 want.index, segment_index));
          if (series_end !== want.last)
            flag_error($sformatf("segment %0d series end: expected %0b got %0b",
                                 want.index, want.last, series_end));
        end
        if ($urandom_range(0, 31) == 0) take_burst = !take_burst;
        take_gap = take_burst ? 0 : $urandom_range(0, 7);
      end else if (take_gap > 0) begin
        take_gap--;
      end
      pop <= (take_gap == 0);
    end
  end

  initial begin : main
    int                    random_count;
    int                    n;
    logic [LEN_REG_W-1:0]  len_data;
    logic [CNT_REG_W-1:0]  cnt_val;
    logic [5:0]            upper_bits;
    logic                  len_first;

    // reset setting, 16 samples per segment: alternating extremes average to -1/2,
    // which truncates toward zero
    for (int i = 0; i < 16; i++) add_sample(i[0] ? 16'h8000 : 16'h7FFF);
    // partial segment, dropped by the restart on the next write
    add_sample(16'h7FFF);
    add_sample(16'h0001);
    // uneven split: 5 samples in segments of 3 and 2
    add_write(REG_SERIES_LENGTH, 13'd5);
    add_write(REG_SEGMENT_COUNT, 13'd2);
    add_sample(16'hFFFF);
    add_sample(16'hFFFF);
    add_sample(16'hFFFE);
    add_sample(16'h7FFF);
    add_sample(16'h7FFF);
    // zero length and zero count both fall back to one; upper data bits ignored
    add_write(REG_SERIES_LENGTH, 13'd0);
    add_write(REG_SEGMENT_COUNT, 13'h1F80);
    add_sample(16'h8000);
    add_sample(16'h0001);
    // count above the maximum, then clamped to the series length
    add_write(REG_SERIES_LENGTH, 13'd3);
    add_write(REG_SEGMENT_COUNT, 13'd100);
    add_sample(16'h1234);
    add_sample(16'hFFFF);
    add_sample(16'h7FFF);

    // random phases: mostly short series, now and then the largest lengths
    random_count = 0;
    while (random_count < RANDOM_SAMPLES) begin
      if ($urandom_range(0, 9) == 0) begin
        len_data = $urandom_range(0, 1) ? 13'd8191 : 13'd4096;
        cnt_val  = $urandom_range(0, 1) ? 7'd127 : 7'd64;
        n        = $urandom_range(70, 140);
      end else begin
        len_data = LEN_REG_W'($urandom_range(0, 40));
        cnt_val  = ($urandom_range(0, 3) == 0) ? CNT_REG_W'($urandom_range(0, 127))
                                                : CNT_REG_W'($urandom_range(0, 12));
        n        = $urandom_range(20, 100);
      end
      upper_bits = 6'($urandom_range(0, 63));
      len_first  = 1'($urandom_range(0, 1));
      if (len_first) add_write(REG_SERIES_LENGTH, len_data);
      add_write(REG_SEGMENT_COUNT, {upper_bits, cnt_val});
      if (!len_first) add_write(REG_SERIES_LENGTH, len_data);
      repeat (n) add_sample(random_sample());
      random_count += n;
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // wait for the stream to drain and every expected word to arrive
    do @(posedge clk);
    while (sample_stream.size() != 0 || push || cfg_write || expected_means.size() != 0);
    // catch stray words that show up late
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : watchdog
    #5000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
